FILE: rtl/ubte_pkg.sv
`timescale 1ns / 1ps
package ubte_pkg;

  localparam int BUF_DEPTH_DEF = 64;
  localparam int CNT_W         = 16;
  localparam int NUM_CNT       = 6;

  localparam logic [7:0] CH_NL = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  // Counter slots
  localparam int IX_OVERRUN = 0;
  localparam int IX_NOISE   = 1;
  localparam int IX_FRAMING = 2;
  localparam int IX_PARITY  = 3;
  localparam int IX_TXFULL  = 4;
  localparam int IX_RXFULL  = 5;

  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_READ  = 2'd1,
    MODE_RECV  = 2'd2,
    MODE_TXRDY = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TX_FULL  = 2'd1,
    ST_RX_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_CR,
    S_RESP
  } state_t;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] data_byte;
    logic       err_overrun;
    logic       err_noise;
    logic       err_framing;
    logic       err_parity;
  } item_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       byte_out;
    logic             byte_valid;
    logic             tx_irq_on;
    logic [CNT_W-1:0] cnt_uart_overrun;
    logic [CNT_W-1:0] cnt_uart_noise;
    logic [CNT_W-1:0] cnt_uart_framing;
    logic [CNT_W-1:0] cnt_uart_parity;
    logic [CNT_W-1:0] cnt_tx_full;
    logic [CNT_W-1:0] cnt_rx_full;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic put_cr;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cr_pending;
  } dp_stat_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

FILE: rtl/uart_buffered_tty_engine.sv
`timescale 1ns / 1ps
// Channel   | Handshake                  | Payload
// ----------+----------------------------+-----------------
// command   | start / busy (start&!busy) | item (item_t)
// result    | done strobe, one cycle     | result (result_t)
// config    | cfg_valid / cfg_ready      | cfg_data (cr_after_newline)
//
// An item passes through S_EXEC and S_RESP before the next start is possible,
// and through S_CR between them when a newline write also appends a carriage
// return: one write port per ring puts the two bytes in on separate cycles, and ring read data is registered.
// Reset (rst, synchronous) empties both rings, clears the counters and the
// transmit interrupt flag, and sets cr_after_newline. No clearing pass.
// The result is shown with done for one cycle; the receiver cannot stall it.
module uart_buffered_tty_engine
  import ubte_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  item_t   item,
  output logic    done,
  output result_t result,
  input  logic    cfg_valid,
  output logic    cfg_ready,
  input  logic    cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  ubte_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  ubte_dp #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .item     (item),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .stat     (stat),
    .result   (result)
  );

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy && !done)
    else $error("accepted transaction did not raise busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result shown while idle");

  a_byte_status: assert property (@(posedge clk) disable iff (rst)
    done && result.byte_valid |-> result.status == ST_OK)
    else $error("byte delivered with error status");
`endif

endmodule

FILE: rtl/ubte_ctrl.sv
`timescale 1ns / 1ps
module ubte_ctrl
  import ubte_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd,
  output logic      busy,
  output logic      done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_EXEC;
      end
      S_EXEC: begin
        // newline with CR insertion needs a second ring write
        state_next = stat.cr_pending ? S_CR : S_RESP;
      end
      S_CR: begin
        state_next = S_RESP;
      end
      S_RESP: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    done = 1'b0;
    unique case (state)
      S_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
      end
      S_CR: begin
        cmd.put_cr = 1'b1;
      end
      S_RESP: begin
        done = 1'b1;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

FILE: rtl/ubte_dp.sv
`timescale 1ns / 1ps
module ubte_dp
  import ubte_pkg::*;
#(
  parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  ctrl_cmd_t cmd,
  input  item_t     item,
  input  logic      cfg_we,
  input  logic      cfg_data,
  output dp_stat_t  stat,
  output result_t   result
);

  localparam int IDX_W = $clog2(BUF_DEPTH);
  localparam logic [IDX_W-1:0] LAST = IDX_W'(BUF_DEPTH - 1);

  logic [7:0] tx_mem [BUF_DEPTH];
  logic [7:0] rx_mem [BUF_DEPTH];
  logic [7:0] tx_rd, rx_rd;

  item_t            cur;
  logic [IDX_W-1:0] tx_head, tx_tail, rx_head, rx_tail;
  logic [IDX_W-1:0] tx_head_nx, tx_tail_nx, rx_head_nx, rx_tail_nx;
  logic             tx_irq;
  logic             cr_en;
  logic [1:0]       status;
  logic             bvalid;
  logic             sel_tx;
  logic [CNT_W-1:0] cnt [NUM_CNT];
  logic [NUM_CNT-1:0] inc;

  logic tx_full, rx_full, tx_empty, rx_empty;
  logic do_tx_put, do_rx_put, do_tx_get, do_rx_get;
  logic [7:0] tx_wdata;

  always_comb begin
    tx_head_nx = (tx_head == LAST) ? '0 : tx_head + 1'b1;
    tx_tail_nx = (tx_tail == LAST) ? '0 : tx_tail + 1'b1;
    rx_head_nx = (rx_head == LAST) ? '0 : rx_head + 1'b1;
    rx_tail_nx = (rx_tail == LAST) ? '0 : rx_tail + 1'b1;

    tx_full  = (tx_head_nx == tx_tail);
    rx_full  = (rx_head_nx == rx_tail);
    tx_empty = (tx_head == tx_tail);
    rx_empty = (rx_head == rx_tail);

    do_tx_put = (cmd.exec && cur.mode == MODE_WRITE) || cmd.put_cr;
    do_rx_put = cmd.exec && cur.mode == MODE_RECV;
    do_rx_get = cmd.exec && cur.mode == MODE_READ && !rx_empty;
    do_tx_get = cmd.exec && cur.mode == MODE_TXRDY && !tx_empty;
    tx_wdata  = cmd.put_cr ? CH_CR : cur.data_byte;

    inc              = '0;
    inc[IX_OVERRUN]  = do_rx_put && cur.err_overrun;
    inc[IX_NOISE]    = do_rx_put && cur.err_noise;
    inc[IX_FRAMING]  = do_rx_put && cur.err_framing;
    inc[IX_PARITY]   = do_rx_put && cur.err_parity;
    inc[IX_TXFULL]   = do_tx_put && tx_full;
    inc[IX_RXFULL]   = do_rx_put && rx_full;

    stat.cr_pending = (cur.mode == MODE_WRITE) && (cur.data_byte == CH_NL) && cr_en;
  end

  // Ring storage, one write and one registered read per ring
  always_ff @(posedge clk) begin
    if (do_tx_put && !tx_full) tx_mem[tx_head] <= tx_wdata;
    if (do_tx_get) tx_rd <= tx_mem[tx_tail];
  end

  always_ff @(posedge clk) begin
    if (do_rx_put && !rx_full) rx_mem[rx_head] <= cur.data_byte;
    if (do_rx_get) rx_rd <= rx_mem[rx_tail];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) cur <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_head <= '0;
      tx_tail <= '0;
      rx_head <= '0;
      rx_tail <= '0;
      tx_irq  <= 1'b0;
      cr_en   <= 1'b1;
      status  <= ST_OK;
      bvalid  <= 1'b0;
      sel_tx  <= 1'b0;
      for (int k = 0; k < NUM_CNT; k++) cnt[k] <= '0;
    end else begin
      if (cfg_we) cr_en <= cfg_data;
      if (cmd.latch) begin
        status <= ST_OK;
        bvalid <= 1'b0;
      end
      if (do_tx_put) begin
        if (tx_full) begin
          status <= ST_TX_FULL;
        end else begin
          tx_head <= tx_head_nx;
          tx_irq  <= 1'b1;
        end
      end
      if (do_rx_put && !rx_full) rx_head <= rx_head_nx;
      if (cmd.exec && cur.mode == MODE_READ && rx_empty) status <= ST_RX_EMPTY;
      if (do_rx_get) begin
        rx_tail <= rx_tail_nx;
        bvalid  <= 1'b1;
        sel_tx  <= 1'b0;
      end
      if (cmd.exec && cur.mode == MODE_TXRDY && tx_empty) tx_irq <= 1'b0;
      if (do_tx_get) begin
        tx_tail <= tx_tail_nx;
        bvalid  <= 1'b1;
        sel_tx  <= 1'b1;
      end
      for (int k = 0; k < NUM_CNT; k++) begin
        if (inc[k]) cnt[k] <= sat_inc(cnt[k]);
      end
    end
  end

  always_comb begin
    result.status           = status;
    result.byte_out         = bvalid ? (sel_tx ? tx_rd : rx_rd) : 8'h00;
    result.byte_valid       = bvalid;
    result.tx_irq_on        = tx_irq;
    result.cnt_uart_overrun = cnt[IX_OVERRUN];
    result.cnt_uart_noise   = cnt[IX_NOISE];
    result.cnt_uart_framing = cnt[IX_FRAMING];
    result.cnt_uart_parity  = cnt[IX_PARITY];
    result.cnt_tx_full      = cnt[IX_TXFULL];
    result.cnt_rx_full      = cnt[IX_RXFULL];
  end

endmodule
